[rtl/xrg_pkg.sv]
// Package: shared types and constants for the xoshiro128** generator.
package xrg_pkg;

   typedef enum logic [1:0] {
      CMD_SEED  = 2'd0,
      CMD_FRAC  = 2'd1,
      CMD_RANGE = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [31:0]        seed_value;
      logic signed [31:0] low_bound;
      logic signed [31:0] high_bound;
   } req_type;

   typedef struct packed {
      logic signed [32:0] value;
      logic               range_error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED_ADD,
      ST_SEED_MIX1,
      ST_SEED_MIX2,
      ST_SEED_STORE,
      ST_CHECK,
      ST_DRAW_MUL5,
      ST_DRAW_MUL9,
      ST_RANGE_MUL,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MUL_MIX1,
      MUL_MIX2,
      MUL_BY5,
      MUL_BY9,
      MUL_RANGE
   } mul_sel_type;

   localparam logic [31:0] SM_GOLDEN = 32'h9e37_79b9;
   localparam logic [31:0] SM_MUL1   = 32'h85eb_ca6b;
   localparam logic [31:0] SM_MUL2   = 32'hc2b2_ae35;
   localparam logic [31:0] XS_MUL5   = 32'd5;
   localparam logic [31:0] XS_MUL9   = 32'd9;

endpackage

[rtl/xoshiro128ss_random_generator_top.sv]
// Top level: xoshiro128** generator with splitmix32 seeding on one shared multiplier.
//
// Usage:
//   req_*  : one command item (seed, fraction draw, ranged integer draw).
//   rsp_*  : one result item per command (value, range_error).
//   csr_*  : auto_seed write, used by an unseeded draw; always ready, write only while idle.
// Sequence (seeded generator, receiver ready):
//   A fraction draw runs its products through the single 32x32 multiplier
//   as x5, then x9; a ranged draw adds x range. Reversed bounds skip the
//   products and return an error; command 3 goes straight to the result.
//   Seeding, where needed, runs first: four splitmix rounds of add, two multiplies and a
//   store. A seed item returns after the four rounds, with no draw.
//   req_ready is high only in idle, which is entered as the result loads, so
//   a new item is taken only after the last one is through.
// Stall:
//   The result sits in an output register until taken; the next item runs
//   meanwhile and waits at its end until the register frees up.
// Reset:
//   Synchronous, active high. Clears control state, the seeded flag and
//   auto_seed. Generator words are written by seeding before any read.
module xoshiro128ss_random_generator_top (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  xrg_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output xrg_pkg::rsp_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [31:0]     csr_data
);
   import xrg_pkg::*;

   state_type          state_ff, state_in;
   mul_sel_type        mul_sel;
   logic               prod_en;
   logic               seed_store;
   logic               draw_step;
   logic               out_load;

   cmd_type            cmd_ff;
   logic signed [31:0] lo_ff, hi_ff;
   logic [31:0]        acc_ff;
   logic [63:0]        prod_ff;
   logic [3:0][31:0]   gen_ff;
   logic               seeded_ff;
   logic [1:0]         cnt_ff;
   logic               err_ff;
   logic [32:0]        range_ff;
   logic [31:0]        word_ff;
   logic [31:0]        auto_seed_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               accept;
   logic               out_free;
   logic [31:0]        p_lo;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        prod_in;
   logic [31:0]        offset;
   rsp_type            rsp_in;
   logic [31:0]        t_w, n0, n1, n2, n3;

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign p_lo      = prod_ff[31:0];
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (cmd_type'(req_data.command) == CMD_SEED)
                  state_in = ST_SEED_ADD;
               else if (cmd_type'(req_data.command) == CMD_NONE)
                  state_in = ST_DONE;
               else if (!seeded_ff)
                  state_in = ST_SEED_ADD;
               else
                  state_in = ST_CHECK;
            end
         end
         ST_SEED_ADD:   state_in = ST_SEED_MIX1;
         ST_SEED_MIX1:  state_in = ST_SEED_MIX2;
         ST_SEED_MIX2:  state_in = ST_SEED_STORE;
         ST_SEED_STORE: begin
            if (cnt_ff != 2'd3)
               state_in = ST_SEED_ADD;
            else if (cmd_ff == CMD_SEED)
               state_in = ST_DONE;
            else
               state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (cmd_ff == CMD_RANGE && lo_ff > hi_ff)
               state_in = ST_DONE;
            else
               state_in = ST_DRAW_MUL5;
         end
         ST_DRAW_MUL5:  state_in = ST_DRAW_MUL9;
         ST_DRAW_MUL9:  state_in = (cmd_ff == CMD_RANGE) ? ST_RANGE_MUL : ST_DONE;
         ST_RANGE_MUL:  state_in = ST_DONE;
         ST_DONE:       state_in = out_free ? ST_IDLE : ST_DONE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready  = 1'b0;
      mul_sel    = MUL_MIX1;
      prod_en    = 1'b0;
      seed_store = 1'b0;
      draw_step  = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:       req_ready = 1'b1;
         ST_SEED_MIX1:  begin mul_sel = MUL_MIX1; prod_en = 1'b1; end
         ST_SEED_MIX2:  begin mul_sel = MUL_MIX2; prod_en = 1'b1; end
         ST_SEED_STORE: seed_store = 1'b1;
         ST_DRAW_MUL5: begin
            mul_sel   = MUL_BY5;
            prod_en   = 1'b1;
            draw_step = 1'b1;
         end
         ST_DRAW_MUL9:  begin mul_sel = MUL_BY9; prod_en = 1'b1; end
         ST_RANGE_MUL:  begin mul_sel = MUL_RANGE; prod_en = 1'b1; end
         ST_DONE:       out_load = out_free;
         default: ;
      endcase
   end

   // shared multiplier operands
   always_comb begin
      unique case (mul_sel)
         MUL_MIX1:  begin mul_a = acc_ff ^ (acc_ff >> 16); mul_b = SM_MUL1; end
         MUL_MIX2:  begin mul_a = p_lo ^ (p_lo >> 13);     mul_b = SM_MUL2; end
         MUL_BY5:   begin mul_a = gen_ff[1];               mul_b = XS_MUL5; end
         MUL_BY9:   begin mul_a = {p_lo[24:0], p_lo[31:25]}; mul_b = XS_MUL9; end
         MUL_RANGE: begin mul_a = p_lo;                    mul_b = range_ff[31:0]; end
         default:   begin mul_a = '0;                      mul_b = '0; end
      endcase
      prod_in = 64'(mul_a) * 64'(mul_b);
   end

   // xoshiro128 state step
   always_comb begin
      t_w = gen_ff[1] << 9;
      n2  = gen_ff[2] ^ gen_ff[0];
      n3  = gen_ff[3] ^ gen_ff[1];
      n1  = gen_ff[1] ^ n2;
      n0  = gen_ff[0] ^ n3;
   end

   // result word
   assign offset = range_ff[32] ? word_ff : prod_ff[63:32];
   always_comb begin
      rsp_in.range_error = err_ff;
      if (err_ff)
         rsp_in.value = '0;
      else if (cmd_ff == CMD_FRAC)
         rsp_in.value = {1'b0, p_lo};
      else if (cmd_ff == CMD_RANGE)
         rsp_in.value = {lo_ff[31], lo_ff} + {1'b0, offset};
      else
         rsp_in.value = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         auto_seed_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready)
            auto_seed_ff <= csr_data;
         if (seed_store && cnt_ff == 2'd3)
            seeded_ff <= 1'b1;
         if (accept)
            cnt_ff <= '0;
         else if (seed_store)
            cnt_ff <= cnt_ff + 2'd1;
         if (out_load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_type'(req_data.command);
         lo_ff  <= req_data.low_bound;
         hi_ff  <= req_data.high_bound;
         err_ff <= 1'b0;
         acc_ff <= (cmd_type'(req_data.command) == CMD_SEED) ?
                   req_data.seed_value : auto_seed_ff;
      end
      if (state_ff == ST_SEED_ADD)
         acc_ff <= acc_ff + SM_GOLDEN;
      if (prod_en)
         prod_ff <= prod_in;
      if (seed_store)
         gen_ff[cnt_ff] <= p_lo ^ (p_lo >> 16);
      if (draw_step) begin
         gen_ff[0] <= n0;
         gen_ff[1] <= n1;
         gen_ff[2] <= n2 ^ t_w;
         gen_ff[3] <= {n3[20:0], n3[31:21]};
      end
      if (state_ff == ST_CHECK) begin
         err_ff   <= (cmd_ff == CMD_RANGE) && (lo_ff > hi_ff);
         range_ff <= {hi_ff[31], hi_ff} - {lo_ff[31], lo_ff} + 33'd1;
      end
      if (state_ff == ST_RANGE_MUL)
         word_ff <= p_lo;
      if (out_load)
         rsp_data_ff <= rsp_in;
   end

endmodule

[rtl/xrg_checker.sv]
// Checker: port-level assertions for the xoshiro128** generator, bound to the top level.
module xrg_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input xrg_pkg::rsp_type rsp_data
);
   import xrg_pkg::*;

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one item in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an item was taken");

   // error results carry a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.range_error |-> rsp_data.value == '0)
      else $error("range error with nonzero value");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind xoshiro128ss_random_generator_top xrg_checker u_xrg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[sim/tb_xoshiro128ss_random_generator_top.sv]
// Self-checking testbench for the xoshiro128** generator with splitmix32 seeding.
module tb_xoshiro128ss_random_generator_top;
   timeunit 1ns;
   timeprecision 1ps;

   import xrg_pkg::*;

   // Splitmix32 constants, kept apart from the package on purpose
   localparam logic [31:0] GOLDEN_STEP = 32'h9e37_79b9;
   localparam logic [31:0] MIX_MUL_A   = 32'h85eb_ca6b;
   localparam logic [31:0] MIX_MUL_B   = 32'hc2b2_ae35;

   localparam logic [31:0] INT_MIN = 32'h8000_0000;
   localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] BOUND_EDGES [7] =
      '{INT_MIN, INT_MIN + 32'd1, 32'hffff_ffff, 32'd0, 32'd1, INT_MAX - 32'd1, INT_MAX};

   // Per-phase knobs for the random part; the last phase runs with no idling at all
   localparam int          RANDOM_PHASES   = 5;
   localparam int          ITEMS_PER_PHASE = 276;
   localparam logic [31:0] FIXED_SEEDS [3] = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000};
   localparam int unsigned GAP_ODDS    [5] = '{3, 12, 2, 7, 0};
   localparam int unsigned STALL_ODDS  [5] = '{10, 3, 16, 2, 0};

   // Worst-case item is an unseeded draw; pad generously
   localparam int          SETTLE_CYCLES  = 40;
   localparam int unsigned WATCHDOG_LIMIT = 1000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;

   // Shadow copy of the generator, reseeded or advanced as accepted items are predicted
   logic [31:0] shadow_words [4];
   logic        shadow_seeded;
   logic [31:0] shadow_auto_seed;

   req_type     cmd_backlog [$];   // items not yet presented on the request channel
   rsp_type     results_due [$];   // predicted results, oldest first
   rsp_type     oldest_due;

   int unsigned send_gap = 0;
   int unsigned hold_gap = 0;
   int unsigned send_gap_odds = 0;
   int unsigned ready_stall_odds = 0;
   int unsigned quiet_cycles = 0;
   int          mismatch_count = 0;

   xoshiro128ss_random_generator_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------

   function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned k);
      return (x << k) | (x >> (32 - k));
   endfunction

   // Four chained splitmix32 rounds fill the four generator words
   function automatic void splitmix_expand(input logic [31:0] seed);
      logic [31:0] acc;
      logic [31:0] z;
      acc = seed;
      for (int i = 0; i < 4; i++) begin
         acc = acc + GOLDEN_STEP;
         z   = acc;
         z   = (z ^ (z >> 16)) * MIX_MUL_A;
         z   = (z ^ (z >> 13)) * MIX_MUL_B;
         shadow_words[i] = z ^ (z >> 16);
      end
      shadow_seeded = 1'b1;
   endfunction

   // One xoshiro128** step: scrambled output from word 1, then the state update
   function automatic logic [31:0] xoshiro_next();
      logic [31:0] word;
      logic [31:0] shifted;
      word    = rotate_left(shadow_words[1] * 32'd5, 7) * 32'd9;
      shifted = shadow_words[1] << 9;
      shadow_words[2] = shadow_words[2] ^ shadow_words[0];
      shadow_words[3] = shadow_words[3] ^ shadow_words[1];
      shadow_words[1] = shadow_words[1] ^ shadow_words[2];
      shadow_words[0] = shadow_words[0] ^ shadow_words[3];
      shadow_words[2] = shadow_words[2] ^ shifted;
      shadow_words[3] = rotate_left(shadow_words[3], 11);
      return word;
   endfunction

   function automatic rsp_type compute_response(input req_type rq);
      rsp_type     rs;
      logic [31:0] word;
      logic [32:0] span;
      logic [64:0] product;
      rs = '0;
      case (cmd_type'(rq.command))
         CMD_SEED: begin
            splitmix_expand(rq.seed_value);
         end
         CMD_FRAC: begin
            if (!shadow_seeded)
               splitmix_expand(shadow_auto_seed);
            rs.value = {1'b0, xoshiro_next()};
         end
         CMD_RANGE: begin
            // Auto-seeding happens even when the bounds turn out reversed
            if (!shadow_seeded)
               splitmix_expand(shadow_auto_seed);
            if ($signed(rq.low_bound) > $signed(rq.high_bound)) begin
               rs.range_error = 1'b1;
            end else begin
               word    = xoshiro_next();
               // span reaches 2^32 for the full signed range, hence 33 bits
               span    = {rq.high_bound[31], rq.high_bound}
                         - {rq.low_bound[31], rq.low_bound} + 33'd1;
               product = {33'd0, word} * {32'd0, span};
               rs.value = {rq.low_bound[31], rq.low_bound} + product[64:32];
            end
         end
         default: begin
            // Unused code: no seeding, no draw, zero result
         end
      endcase
      return rs;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------

   function automatic void queue_cmd(input cmd_type op, input logic [31:0] seed,
                                     input logic [31:0] lo, input logic [31:0] hi);
      req_type rq;
      rq.command    = op;
      rq.seed_value = seed;
      rq.low_bound  = lo;
      rq.high_bound = hi;
      cmd_backlog.push_back(rq);
   endfunction

   // Mostly ranged and fraction draws with well-ordered bounds; some reseeds,
   // reversed bounds and unused codes mixed in
   function automatic req_type random_request();
      req_type     rq;
      int unsigned pick;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] swap;
      logic [31:0] span;
      rq.seed_value = $urandom;
      a    = $urandom;
      b    = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         rq.command = CMD_SEED;
      else if (pick < 45)
         rq.command = CMD_FRAC;
      else if (pick < 92)
         rq.command = CMD_RANGE;
      else
         rq.command = CMD_NONE;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin           // wide range, ordered
            if ($signed(a) > $signed(b)) begin
               swap = a; a = b; b = swap;
            end
         end
         4, 5, 6: begin              // narrow range, pushed down off the top if it wraps
            span = $urandom_range(0, 255);
            b    = a + span;
            if ($signed(b) < $signed(a)) begin
               b = INT_MAX;
               a = INT_MAX - span;
            end
         end
         7: begin                    // bounds from the edges of the signed range
            if ($urandom_range(0, 7) != 7) a = BOUND_EDGES[$urandom_range(0, 6)];
            if ($urandom_range(0, 7) != 7) b = BOUND_EDGES[$urandom_range(0, 6)];
            if ($urandom_range(0, 3) != 0 && $signed(a) > $signed(b)) begin
               swap = a; a = b; b = swap;
            end
         end
         8: begin                    // single-value range
            b = a;
         end
         default: begin              // reversed bounds
            if ($signed(a) < $signed(b)) begin
               swap = a; a = b; b = swap;
            end
         end
      endcase
      rq.low_bound  = a;
      rq.high_bound = b;
      return rq;
   endfunction

   task automatic write_auto_seed(input logic [31:0] seed);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= seed;
      do @(posedge clock); while (!csr_ready);
      shadow_auto_seed = seed;
      csr_valid <= 1'b0;
   endtask

   // Hold off until every item is sent and every result is back, then let the block settle
   task automatic settle();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_valid || results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Request driver: presents backlog items, predicts on accept, inserts idle bursts
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready)
            results_due.push_back(compute_response(req_data));
         // Slot is free when nothing is held or the held item just went in
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (cmd_backlog.size() == 0) begin
               req_valid <= 1'b0;
            end else if (send_gap_odds != 0 && $urandom_range(1, send_gap_odds) == 1) begin
               send_gap  <= $urandom_range(0, 13);   // start an idle burst
               req_valid <= 1'b0;
            end else begin
               req_data  <= cmd_backlog.pop_front();
               req_valid <= 1'b1;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Result monitor: back-pressure bursts and in-order field checks
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_gap  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, value %h range_error %b", $time,
                        rsp_data.value, rsp_data.range_error);
            end else begin
               oldest_due = results_due.pop_front();
               if (rsp_data.value !== oldest_due.value) begin
                  mismatch_count++;
                  $display("%0t: value mismatch, expected %h actual %h", $time,
                           oldest_due.value, rsp_data.value);
               end
               if (rsp_data.range_error !== oldest_due.range_error) begin
                  mismatch_count++;
                  $display("%0t: range_error mismatch, expected %b actual %b", $time,
                           oldest_due.range_error, rsp_data.range_error);
               end
            end
         end
         if (hold_gap != 0) begin
            hold_gap  <= hold_gap - 1;
            rsp_ready <= 1'b0;
         end else if (ready_stall_odds != 0 && $urandom_range(1, ready_stall_odds) == 1) begin
            hold_gap  <= $urandom_range(0, 13);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: any handshake on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequence: reset, directed items, then random phases between register writes
   // ---------------------------------------------------------------------------------------
   initial begin
      logic [31:0] next_seed;

      for (int i = 0; i < 4; i++)
         shadow_words[i] = '0;
      shadow_seeded    = 1'b0;
      shadow_auto_seed = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // The generator is unseeded only once per run; use it with the top seed value
      send_gap_odds    = 3;
      ready_stall_odds = 4;
      write_auto_seed(32'hffff_ffff);
      @(negedge clock);

      // Unused code first: must not trigger auto-seeding
      queue_cmd(CMD_NONE,  $urandom, $urandom, $urandom);
      // Reversed bounds on an unseeded generator: seeds, flags, draws nothing
      queue_cmd(CMD_RANGE, $urandom, 32'd5, -32'sd3);
      queue_cmd(CMD_FRAC,  $urandom, $urandom, $urandom);
      queue_cmd(CMD_SEED,  32'h0000_0000, $urandom, $urandom);
      queue_cmd(CMD_FRAC,  $urandom, $urandom, $urandom);
      queue_cmd(CMD_RANGE, $urandom, INT_MIN, INT_MAX);        // full range, span 2^32
      queue_cmd(CMD_SEED,  32'hffff_ffff, $urandom, $urandom);
      queue_cmd(CMD_FRAC,  $urandom, $urandom, $urandom);
      queue_cmd(CMD_RANGE, $urandom, INT_MIN, INT_MIN);
      queue_cmd(CMD_RANGE, $urandom, INT_MAX, INT_MAX);
      queue_cmd(CMD_RANGE, $urandom, 32'd0, 32'd0);
      queue_cmd(CMD_RANGE, $urandom, -32'sd1, 32'd0);
      queue_cmd(CMD_RANGE, $urandom, INT_MAX, INT_MIN);        // reversed, extreme
      queue_cmd(CMD_RANGE, $urandom, INT_MAX, INT_MAX - 32'd1); // reversed by one
      queue_cmd(CMD_RANGE, $urandom, INT_MIN, INT_MIN + 32'd1);
      queue_cmd(CMD_RANGE, $urandom, -32'sd100, 32'd100);
      queue_cmd(CMD_SEED,  32'h8000_0000, $urandom, $urandom);
      queue_cmd(CMD_NONE,  $urandom, $urandom, $urandom);
      queue_cmd(CMD_RANGE, $urandom, INT_MIN, INT_MAX);
      queue_cmd(CMD_SEED,  32'h7fff_ffff, $urandom, $urandom);
      queue_cmd(CMD_RANGE, $urandom, 32'd0, INT_MAX);
      queue_cmd(CMD_RANGE, $urandom, INT_MIN, -32'sd1);
      queue_cmd(CMD_FRAC,  $urandom, $urandom, $urandom);
      settle();

      // Random phases; each starts idle with a fresh auto_seed and its own idling mix
      for (int pass_no = 0; pass_no < RANDOM_PHASES; pass_no++) begin
         next_seed = (pass_no % 2 == 1) ? $urandom : FIXED_SEEDS[pass_no / 2];
         write_auto_seed(next_seed);
         send_gap_odds    = GAP_ODDS[pass_no];
         ready_stall_odds = STALL_ODDS[pass_no];
         @(negedge clock);
         repeat (ITEMS_PER_PHASE) cmd_backlog.push_back(random_request());
         settle();
      end

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
